// ===== sv/rau_pkg.sv =====
// Package for the rational arithmetic unit: item structs, operation codes,
// queue entry and back-end state types. No dependencies.
package rau_pkg;

  localparam int OPW   = 16;
  localparam int DENW  = OPW - 1;
  localparam int NUMW  = 32;
  localparam int DENRW = 31;
  localparam int QD    = 2;
  localparam int QAW   = 1;

  localparam logic [2:0] FN_ADD = 3'd0;
  localparam logic [2:0] FN_SUB = 3'd1;
  localparam logic [2:0] FN_MUL = 3'd2;
  localparam logic [2:0] FN_DIV = 3'd3;
  localparam logic [2:0] FN_CMP = 3'd4;

  typedef struct packed {
    logic [2:0]             func;
    logic signed [OPW-1:0]  a_num;
    logic [DENW-1:0]        a_den;
    logic signed [OPW-1:0]  b_num;
    logic [DENW-1:0]        b_den;
  } in_item_t;

  typedef struct packed {
    logic signed [NUMW-1:0] res_num;
    logic [DENRW-1:0]       res_den;
    logic                   is_equal;
    logic                   status;
  } out_item_t;

  typedef struct packed {
    logic             reduce;
    logic             neg;
    logic [NUMW-1:0]  nm;
    logic [DENRW-1:0] dm;
    out_item_t        direct;
  } q_entry_t;

  typedef struct packed {
    logic push;
    logic full;
  } q_wr_ctl_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_TWOS,
    BK_ODDA,
    BK_GCD,
    BK_DIV,
    BK_DONE
  } bk_state_t;

endpackage

// ===== sv/rau_front.sv =====
// Front end: accepts items, forms cross products and classifies each item.
// Depends on rau_pkg.
module rau_front import rau_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_push,
  output logic      in_full,
  input  in_item_t  in_item,
  output q_wr_ctl_t q_wr,
  input  logic      q_full,
  output q_entry_t  q_data
);

  logic                   s1_valid_r;
  logic [2:0]             func_r;
  logic                   den_zero_r;
  logic signed [31:0]     p_ab_r, p_ba_r, p_nn_r;
  logic [2*DENW-1:0]      p_dd_r;
  logic                   accept;
  logic signed [32:0]     n_s;
  logic signed [31:0]     d_s;
  logic [32:0]            n_mag;
  logic [31:0]            d_mag;
  logic [NUMW-1:0]        nm;
  logic [DENRW-1:0]       dm;

  assign in_full = s1_valid_r && q_full;
  assign accept  = in_push && !in_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
    end else if (!q_full) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      func_r     <= in_item.func;
      den_zero_r <= (in_item.a_den == '0) || (in_item.b_den == '0);
      p_ab_r     <= 32'(in_item.a_num) * 32'($signed({1'b0, in_item.b_den}));
      p_ba_r     <= 32'($signed({1'b0, in_item.a_den})) * 32'(in_item.b_num);
      p_nn_r     <= 32'(in_item.a_num) * 32'(in_item.b_num);
      p_dd_r     <= in_item.a_den * in_item.b_den;
    end
  end

  always_comb begin
    n_s = {p_ab_r[31], p_ab_r};
    d_s = {2'b00, p_dd_r};
    unique case (func_r)
      FN_ADD:  n_s = {p_ab_r[31], p_ab_r} + {p_ba_r[31], p_ba_r};
      FN_SUB:  n_s = {p_ab_r[31], p_ab_r} - {p_ba_r[31], p_ba_r};
      FN_MUL:  n_s = {p_nn_r[31], p_nn_r};
      FN_DIV:  d_s = p_ba_r;
      default: n_s = {p_ab_r[31], p_ab_r};
    endcase
    n_mag = n_s[32] ? 33'(-n_s) : 33'(n_s);
    d_mag = d_s[31] ? 32'(-d_s) : 32'(d_s);
    nm    = n_mag[NUMW-1:0];
    dm    = d_mag[DENRW-1:0];

    q_data = '0;
    priority if (func_r > FN_CMP) begin
      q_data = '0;
    end else if (den_zero_r) begin
      q_data.direct.status = 1'b1;
    end else if (func_r == FN_CMP) begin
      q_data.direct.is_equal = (p_ab_r == p_ba_r);
    end else if (d_s == '0) begin
      q_data.direct.status = 1'b1;
    end else if (nm == '0) begin
      q_data.direct.res_den = DENRW'(1);
    end else begin
      q_data.reduce = 1'b1;
      q_data.neg    = n_s[32] ^ d_s[31];
      q_data.nm     = nm;
      q_data.dm     = dm;
    end
  end

  assign q_wr.push = s1_valid_r && !q_full;
  assign q_wr.full = q_full;

endmodule

// ===== sv/rau_queue.sv =====
// Short register queue between the front and back ends.
// Depends on rau_pkg.
module rau_queue import rau_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  q_wr_ctl_t q_wr,
  input  q_entry_t  wr_data,
  output logic      full,
  input  logic      pop,
  output logic      empty,
  output q_entry_t  rd_data
);

  q_entry_t         mem_r [QD];
  logic [QAW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QAW:0]     cnt_r;
  logic             do_push, do_pop;

  assign full    = (cnt_r == (QAW+1)'(QD));
  assign empty   = (cnt_r == '0);
  assign rd_data = mem_r[rd_ptr_r];
  assign do_push = q_wr.push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      cnt_r <= cnt_r + (QAW+1)'(do_push) - (QAW+1)'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= wr_data;
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (QAW+1)'(QD))
    else $error("queue count exceeds depth");

endmodule

// ===== sv/rau_back.sv =====
// Back end: binary GCD and two restoring dividers reduce each fraction marked
// for reduction; other items go straight to the result register. Depends on rau_pkg.
module rau_back import rau_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_empty,
  input  q_entry_t  q_data,
  output logic      q_pop,
  output logic      out_empty,
  input  logic      out_pop,
  output out_item_t out_item
);

  bk_state_t        state_r, state_nxt;
  logic [31:0]      a_r, a_nxt, b_r, b_nxt, g_r, g_nxt;
  logic [4:0]       k_r, k_nxt, cnt_r, cnt_nxt;
  logic [31:0]      qn_r, qn_nxt, qd_r, qd_nxt;
  logic [32:0]      rn_r, rn_nxt, rd_r, rd_nxt;
  logic             neg_r, neg_nxt;
  out_item_t        out_r, out_nxt;
  logic             out_valid_r, load;
  logic             out_free;
  logic [32:0]      rn_sh, rd_sh;

  assign out_free  = !out_valid_r || out_pop;
  assign out_empty = !out_valid_r;
  assign out_item  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    g_r   <= g_nxt;
    k_r   <= k_nxt;
    cnt_r <= cnt_nxt;
    qn_r  <= qn_nxt;
    qd_r  <= qd_nxt;
    rn_r  <= rn_nxt;
    rd_r  <= rd_nxt;
    neg_r <= neg_nxt;
    out_r <= out_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    a_nxt = a_r;  b_nxt = b_r;  g_nxt = g_r;  k_nxt = k_r;  cnt_nxt = cnt_r;
    qn_nxt = qn_r;  qd_nxt = qd_r;  rn_nxt = rn_r;  rd_nxt = rd_r;
    neg_nxt = neg_r;  out_nxt = out_r;
    q_pop = 1'b0;
    load  = 1'b0;
    rn_sh = {rn_r[31:0], qn_r[31]};
    rd_sh = {rd_r[31:0], qd_r[31]};
    unique case (state_r)
      BK_IDLE: begin
        if (!q_empty) begin
          if (q_data.reduce) begin
            q_pop     = 1'b1;
            a_nxt     = q_data.nm;
            b_nxt     = {1'b0, q_data.dm};
            qn_nxt    = q_data.nm;
            qd_nxt    = {1'b0, q_data.dm};
            neg_nxt   = q_data.neg;
            k_nxt     = '0;
            state_nxt = BK_TWOS;
          end else if (out_free) begin
            q_pop   = 1'b1;
            load    = 1'b1;
            out_nxt = q_data.direct;
          end
        end
      end
      BK_TWOS: begin
        if (!(a_r[0] || b_r[0])) begin
          a_nxt = a_r >> 1;
          b_nxt = b_r >> 1;
          k_nxt = k_r + 5'd1;
        end else begin
          state_nxt = BK_ODDA;
        end
      end
      BK_ODDA: begin
        if (!a_r[0]) begin
          a_nxt = a_r >> 1;
        end else begin
          state_nxt = BK_GCD;
        end
      end
      BK_GCD: begin
        priority if (b_r == '0) begin
          g_nxt     = a_r << k_r;
          rn_nxt    = '0;
          rd_nxt    = '0;
          cnt_nxt   = '0;
          state_nxt = BK_DIV;
        end else if (!b_r[0]) begin
          b_nxt = b_r >> 1;
        end else if (a_r > b_r) begin
          a_nxt = b_r;
          b_nxt = a_r - b_r;
        end else begin
          b_nxt = b_r - a_r;
        end
      end
      BK_DIV: begin
        if (rn_sh >= {1'b0, g_r}) begin
          rn_nxt = rn_sh - {1'b0, g_r};
          qn_nxt = {qn_r[30:0], 1'b1};
        end else begin
          rn_nxt = rn_sh;
          qn_nxt = {qn_r[30:0], 1'b0};
        end
        if (rd_sh >= {1'b0, g_r}) begin
          rd_nxt = rd_sh - {1'b0, g_r};
          qd_nxt = {qd_r[30:0], 1'b1};
        end else begin
          rd_nxt = rd_sh;
          qd_nxt = {qd_r[30:0], 1'b0};
        end
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'd31) state_nxt = BK_DONE;
      end
      BK_DONE: begin
        if (out_free) begin
          load             = 1'b1;
          out_nxt.res_num  = neg_r ? -$signed(qn_r) : $signed(qn_r);
          out_nxt.res_den  = qd_r[DENRW-1:0];
          out_nxt.is_equal = 1'b0;
          out_nxt.status   = 1'b0;
          state_nxt        = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == BK_DIV |-> g_r != '0)
    else $error("divider started with a zero divisor");

  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == BK_DONE |-> rn_r == '0 && rd_r == '0)
    else $error("reduction left a remainder");

  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == BK_GCD |-> a_r[0])
    else $error("GCD loop entered with an even operand");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.status |-> out_r.res_den == '0 && out_r.res_num == '0)
    else $error("error result carries a fraction");

endmodule

// ===== sv/rational_arith_unit_top.sv =====
// Top level of the rational arithmetic unit: front end, queue, back end.
// Depends on rau_pkg, rau_front, rau_queue and rau_back.
// Path: errors, compares and zero results pass the front-end register, the queue and
// the result register; a reduced result also runs the one-step-per-cycle binary GCD
// loop and the two dividers before it reaches the result register.
// Throughput: one item per reduction; the queue lets the front keep taking items until it is full.
// Reset: synchronous active-low rst_n empties the queue and the output register.
module rational_arith_unit_top import rau_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_push,
  output logic      in_full,
  input  in_item_t  in_item,
  output logic      out_empty,
  input  logic      out_pop,
  output out_item_t out_item
);

  q_wr_ctl_t q_wr;
  q_entry_t  q_wdata, q_rdata;
  logic      q_full, q_empty, q_pop;

  rau_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_full (in_full),
    .in_item (in_item),
    .q_wr    (q_wr),
    .q_full  (q_full),
    .q_data  (q_wdata)
  );

  rau_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_wr    (q_wr),
    .wr_data (q_wdata),
    .full    (q_full),
    .pop     (q_pop),
    .empty   (q_empty),
    .rd_data (q_rdata)
  );

  rau_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_data    (q_rdata),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

endmodule
